>>> rtl/fmv_pkg.sv
// Package: shared constants, types and helper functions of the FM voice.
`default_nettype none
package fmv_pkg;

    localparam int FRAC_BITS_DEF    = 15;
    localparam int SINE_ENTRIES_DEF = 256;

    localparam logic [11:0] DAC_MID  = 12'd2048;
    localparam logic [31:0] STEP_SAT = 32'h7fff_ffff;
    localparam longint      HALF_PI_Q30 = 64'sd1686629713;
    localparam longint      SINE_AMP    = 64'sd2047;

    localparam logic [2:0] REG_ATTACK      = 3'd0;
    localparam logic [2:0] REG_SUSTAIN     = 3'd1;
    localparam logic [2:0] REG_DECAY       = 3'd2;
    localparam logic [2:0] REG_MOD_ATTACK  = 3'd3;
    localparam logic [2:0] REG_MOD_SUSTAIN = 3'd4;
    localparam logic [2:0] REG_MOD_DECAY   = 3'd5;
    localparam logic [2:0] REG_PEAK_DEPTH  = 3'd6;
    localparam logic [2:0] REG_LINEAR      = 3'd7;

    typedef logic signed [63:0] wide_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7fff_ffff) begin
            r = 32'sh7fff_ffff;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sine_entry(input int i, input int bits,
                                                      input int fb);
        longint quarter, q, r, k, x, x2, term, sum, v;
        quarter = 64'sd1 <<< (bits - 2);
        q       = (longint'(i) >>> (bits - 2)) & 64'sd3;
        r       = longint'(i) & (quarter - 64'sd1);
        k       = q[0] ? (quarter - r) : r;
        x       = (k * HALF_PI_Q30) >>> (bits - 2);
        x2      = (x * x) >>> 30;
        term    = x;
        sum     = x;
        term = ((term * x2) >>> 30) / 6;   sum = sum - term;
        term = ((term * x2) >>> 30) / 20;  sum = sum + term;
        term = ((term * x2) >>> 30) / 42;  sum = sum - term;
        term = ((term * x2) >>> 30) / 72;  sum = sum + term;
        term = ((term * x2) >>> 30) / 110; sum = sum - term;
        term = ((term * x2) >>> 30) / 156; sum = sum + term;
        term = ((term * x2) >>> 30) / 210; sum = sum - term;
        v = (SINE_AMP * sum) >>> (30 - fb);
        return sat32(q[1] ? -v : v);
    endfunction

endpackage
`default_nettype wire

>>> rtl/fm_voice_with_envelopes_top.sv
// Top level: FM voice sequencer, envelope state, APB registers and stream ports.
//
// One FM voice with attack-sustain-decay envelopes on amplitude and modulation
// depth. Each input transfer yields exactly one output transfer. A sample tick
// while playing runs two serial multiplies plus table reads and sequencing; with
// parabolic decay in the decay phase it adds a serial multiply and a serial
// divide. A silent tick skips the multiplies. A note start adds four serial
// divides. A stalled output holds the voice in its output state until the
// previous result is taken. Registers are to be written over APB only while
// the voice is idle; the block itself does not enforce this.
`default_nettype none
module fm_voice_with_envelopes_top
    import fmv_pkg::*;
#(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // carrier_increment[31:0], modulator_increment[63:32]
    input  wire logic        s_tuser,   // action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // dac_code[11:0], playing[12], zero[15:13]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int IDX_BITS = $clog2(SINE_ENTRIES);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DSTART = 4'd1;
    localparam logic [3:0] S_DWAIT  = 4'd2;
    localparam logic [3:0] S_CHECK  = 4'd3;
    localparam logic [3:0] S_MADDR  = 4'd4;
    localparam logic [3:0] S_MSTART = 4'd5;
    localparam logic [3:0] S_MWAIT  = 4'd6;
    localparam logic [3:0] S_CADDR  = 4'd7;
    localparam logic [3:0] S_AMP    = 4'd8;
    localparam logic [3:0] S_PWAIT  = 4'd9;
    localparam logic [3:0] S_PDWAIT = 4'd10;
    localparam logic [3:0] S_CSTART = 4'd11;
    localparam logic [3:0] S_CWAIT  = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;

    logic [15:0] attack_reg, sustain_reg, decay_reg;
    logic [15:0] mattack_reg, msustain_reg, mdecay_reg;
    logic [30:0] peak_reg;
    logic        linear_reg;

    logic [3:0]  state_reg;
    logic [1:0]  div_sel_reg;
    logic [31:0] in_cinc_reg, in_minc_reg;
    logic [31:0] cphase_reg, mphase_reg, cstep_reg, mstep_reg, elapsed_reg;
    logic signed [31:0] amp_reg, depth_reg, cwave_reg;
    logic signed [31:0] step_reg [4];
    logic [32:0] twice_reg;
    logic [11:0] res_code_reg;
    logic        res_play_reg;
    logic        m_tvalid_reg;
    logic [11:0] out_code_reg;
    logic        out_play_reg;

    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    logic        mul_start, mul_done;
    wide_t       mul_mcand, mul_prod;
    logic [31:0] mul_mplier;
    logic        div_start, div_done;
    logic [63:0] div_dividend, div_quot;
    logic [15:0] div_divisor;
    logic [IDX_BITS-1:0] rom_addr;
    logic signed [31:0]  rom_q;

    logic [32:0] n_ext;
    logic [17:0] msum_as, msum_all, csum_as, csum_all;
    logic [31:0] t_full;
    logic [32:0] dk_twice;
    logic [15:0] sel_len;
    logic [31:0] step_val;
    wide_t       par_amp;
    wide_t       fm_shift;
    wide_t       code_shift;
    logic        par_go;
    logic        out_fire;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_reg   <= 16'd1000;
            sustain_reg  <= 16'd4000;
            decay_reg    <= 16'd8000;
            mattack_reg  <= 16'd1000;
            msustain_reg <= 16'd4000;
            mdecay_reg   <= 16'd8000;
            peak_reg     <= '0;
            linear_reg   <= 1'b1;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ATTACK:      attack_reg   <= pwdata[15:0];
                REG_SUSTAIN:     sustain_reg  <= pwdata[15:0];
                REG_DECAY:       decay_reg    <= pwdata[15:0];
                REG_MOD_ATTACK:  mattack_reg  <= pwdata[15:0];
                REG_MOD_SUSTAIN: msustain_reg <= pwdata[15:0];
                REG_MOD_DECAY:   mdecay_reg   <= pwdata[15:0];
                REG_PEAK_DEPTH:  peak_reg     <= pwdata[30:0];
                REG_LINEAR:      linear_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_ATTACK:      prdata = {16'd0, attack_reg};
            REG_SUSTAIN:     prdata = {16'd0, sustain_reg};
            REG_DECAY:       prdata = {16'd0, decay_reg};
            REG_MOD_ATTACK:  prdata = {16'd0, mattack_reg};
            REG_MOD_SUSTAIN: prdata = {16'd0, msustain_reg};
            REG_MOD_DECAY:   prdata = {16'd0, mdecay_reg};
            REG_PEAK_DEPTH:  prdata = {1'b0, peak_reg};
            REG_LINEAR:      prdata = {31'd0, linear_reg};
            default:         prdata = '0;
        endcase
    end

    fmv_mul u_mul (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mul_start),
        .mcand    (mul_mcand),
        .mplier   (mul_mplier),
        .done     (mul_done),
        .prod_reg (mul_prod)
    );

    fmv_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot_reg (div_quot)
    );

    fmv_rom #(
        .FRAC_BITS    (FRAC_BITS),
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_rom (
        .aclk     (aclk),
        .addr     (rom_addr),
        .data_reg (rom_q)
    );

    assign rom_addr = (state_reg == S_MADDR) ? mphase_reg[31 -: IDX_BITS]
                                             : cphase_reg[31 -: IDX_BITS];

    assign n_ext    = {1'b0, elapsed_reg};
    assign msum_as  = {2'b00, mattack_reg} + {2'b00, msustain_reg};
    assign msum_all = msum_as + {2'b00, mdecay_reg};
    assign csum_as  = {2'b00, attack_reg} + {2'b00, sustain_reg};
    assign csum_all = csum_as + {2'b00, decay_reg};
    assign t_full   = elapsed_reg - {14'd0, csum_as};
    assign dk_twice = {step_reg[1][31:0], 1'b0};
    assign par_go   = (n_ext < {15'd0, csum_all}) && (n_ext > {15'd0, csum_as})
                      && !linear_reg;
    assign out_fire = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    always_comb begin
        case (div_sel_reg)
            2'd0:    sel_len = attack_reg;
            2'd1:    sel_len = decay_reg;
            2'd2:    sel_len = mattack_reg;
            default: sel_len = mdecay_reg;
        endcase
    end

    assign step_val = (sel_len == 16'd0) ? STEP_SAT : div_quot[31:0];

    always_comb begin
        mul_start  = 1'b0;
        mul_mcand  = '0;
        mul_mplier = '0;
        case (state_reg)
            S_MSTART: begin
                mul_start  = 1'b1;
                mul_mcand  = wide_t'(rom_q);
                mul_mplier = depth_reg;
            end
            S_AMP: begin
                mul_start  = par_go;
                mul_mcand  = wide_t'({31'd0, dk_twice});
                mul_mplier = {16'd0, t_full[15:0]};
            end
            S_CSTART: begin
                mul_start  = 1'b1;
                mul_mcand  = wide_t'(cwave_reg);
                mul_mplier = amp_reg;
            end
            default: ;
        endcase
    end

    always_comb begin
        div_start    = 1'b0;
        div_dividend = mul_prod;
        div_divisor  = decay_reg;
        if (state_reg == S_DSTART) begin
            div_start    = 1'b1;
            div_divisor  = sel_len;
            div_dividend = (div_sel_reg[1]) ? {33'd0, peak_reg}
                                            : (64'd1 << FRAC_BITS);
        end else if (state_reg == S_PWAIT) begin
            div_start = mul_done;
        end
    end

    assign par_amp    = wide_t'(amp_reg) - wide_t'({31'd0, twice_reg})
                        + $signed(div_quot);
    assign fm_shift   = mul_prod >>> FRAC_BITS;
    assign code_shift = mul_prod >>> (2 * FRAC_BITS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            div_sel_reg  <= '0;
            cphase_reg   <= '0;
            mphase_reg   <= '0;
            amp_reg      <= '0;
            depth_reg    <= '0;
            elapsed_reg  <= '0;
            cstep_reg    <= '0;
            mstep_reg    <= '0;
            for (int i = 0; i < 4; i++) begin
                step_reg[i] <= '0;
            end
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        in_cinc_reg <= s_tdata[31:0];
                        in_minc_reg <= s_tdata[63:32];
                        div_sel_reg <= '0;
                        state_reg   <= s_tuser ? S_DSTART : S_CHECK;
                    end
                end
                S_DSTART: state_reg <= S_DWAIT;
                S_DWAIT: begin
                    if (div_done) begin
                        step_reg[div_sel_reg] <= step_val;
                        if (div_sel_reg == 2'd3) begin
                            cstep_reg   <= in_cinc_reg;
                            mstep_reg   <= in_minc_reg;
                            amp_reg     <= step_reg[0];
                            depth_reg   <= step_reg[2];
                            elapsed_reg <= '0;
                            cphase_reg  <= '0;
                            state_reg   <= S_CHECK;
                        end else begin
                            div_sel_reg <= div_sel_reg + 2'd1;
                            state_reg   <= S_DSTART;
                        end
                    end
                end
                S_CHECK: begin
                    if (amp_reg > 32'sd0) begin
                        res_play_reg <= 1'b1;
                        mphase_reg   <= mphase_reg + mstep_reg;
                        state_reg    <= S_MADDR;
                    end else begin
                        res_play_reg <= 1'b0;
                        res_code_reg <= DAC_MID;
                        state_reg    <= S_OUT;
                    end
                end
                S_MADDR: begin
                    if (n_ext < {15'd0, msum_all}) begin
                        if (n_ext <= {17'd0, mattack_reg}) begin
                            depth_reg <= sat32(wide_t'(depth_reg) + wide_t'(step_reg[2]));
                        end else if (n_ext > {15'd0, msum_as}) begin
                            depth_reg <= sat32(wide_t'(depth_reg) - wide_t'(step_reg[3]));
                        end
                    end else begin
                        depth_reg <= '0;
                    end
                    state_reg <= S_MSTART;
                end
                S_MSTART: state_reg <= S_MWAIT;
                S_MWAIT: begin
                    if (mul_done) begin
                        cphase_reg <= cphase_reg + cstep_reg + fm_shift[31:0];
                        state_reg  <= S_CADDR;
                    end
                end
                S_CADDR: state_reg <= S_AMP;
                S_AMP: begin
                    cwave_reg <= rom_q;
                    twice_reg <= dk_twice;
                    state_reg <= par_go ? S_PWAIT : S_CSTART;
                    if (n_ext < {15'd0, csum_all}) begin
                        if (n_ext <= {17'd0, attack_reg}) begin
                            amp_reg <= sat32(wide_t'(amp_reg) + wide_t'(step_reg[0]));
                        end else if (n_ext > {15'd0, csum_as}) begin
                            if (linear_reg) begin
                                amp_reg <= sat32(wide_t'(amp_reg) - wide_t'(step_reg[1]));
                            end
                        end
                    end else begin
                        amp_reg <= '0;
                    end
                end
                S_PWAIT: begin
                    if (mul_done) begin
                        state_reg <= S_PDWAIT;
                    end
                end
                S_PDWAIT: begin
                    if (div_done) begin
                        amp_reg   <= sat32(par_amp);
                        state_reg <= S_CSTART;
                    end
                end
                S_CSTART: state_reg <= S_CWAIT;
                S_CWAIT: begin
                    if (mul_done) begin
                        res_code_reg <= code_shift[11:0] + DAC_MID;
                        if (elapsed_reg != 32'hffff_ffff) begin
                            elapsed_reg <= elapsed_reg + 32'd1;
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_fire) begin
                        out_code_reg <= res_code_reg;
                        out_play_reg <= res_play_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'd0, out_play_reg, out_code_reg};

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_tready)
        else $error("input ready while voice busy");

    a_silent_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[12]) |-> (m_tdata[11:0] == DAC_MID))
        else $error("silent sample not at midscale");

    a_note_divides: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser) |=> (state_reg == S_DSTART))
        else $error("note start did not begin step division");

endmodule
`default_nettype wire

>>> rtl/fmv_rom.sv
// Sine table with registered read.
`default_nettype none
module fmv_rom
    import fmv_pkg::*;
#(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int SINE_ENTRIES = SINE_ENTRIES_DEF,
    localparam int IDX_BITS    = $clog2(SINE_ENTRIES)
) (
    input  wire logic                aclk,
    input  wire logic [IDX_BITS-1:0] addr,
    output logic signed [31:0]       data_reg
);

    logic signed [31:0] rom [SINE_ENTRIES];

    for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_rom
        assign rom[g] = sine_entry(g, IDX_BITS, FRAC_BITS);
    end

    always_ff @(posedge aclk) begin
        data_reg <= rom[addr];
    end

endmodule
`default_nettype wire

>>> rtl/fmv_mul.sv
// Bit-serial signed multiplier: 64-bit multiplicand by 32-bit multiplier.
`default_nettype none
module fmv_mul
    import fmv_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire wide_t       mcand,
    input  wire logic [31:0] mplier,
    output logic             done,
    output wide_t            prod_reg
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    wide_t       mc_reg;
    logic [31:0] mp_reg;
    wide_t       prod_next;

    always_comb begin
        prod_next = prod_reg;
        if (mp_reg[0]) begin
            prod_next = (cnt_reg == 5'd31) ? prod_reg - mc_reg : prod_reg + mc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            prod_reg <= '0;
            mc_reg   <= mcand;
            mp_reg   <= mplier;
        end else if (busy_reg) begin
            prod_reg <= prod_next;
            mc_reg   <= mc_reg <<< 1;
            mp_reg   <= mp_reg >> 1;
        end
    end

    assign done = done_reg;

endmodule
`default_nettype wire

>>> rtl/fmv_div.sv
// Bit-serial restoring divider: 64-bit unsigned dividend by 16-bit divisor.
`default_nettype none
module fmv_div
    import fmv_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             done,
    output logic [63:0]      quot_reg
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [15:0] rem_reg;
    logic [15:0] dsr_reg;
    logic [16:0] shifted;
    logic [16:0] trial;

    assign shifted = {rem_reg, quot_reg[63]};
    assign trial   = shifted - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dsr_reg  <= divisor;
        end else if (busy_reg) begin
            if (!trial[16]) begin
                rem_reg  <= trial[15:0];
                quot_reg <= {quot_reg[62:0], 1'b1};
            end else begin
                rem_reg  <= shifted[15:0];
                quot_reg <= {quot_reg[62:0], 1'b0};
            end
        end
    end

    assign done = done_reg;

endmodule
`default_nettype wire

>>> verif/fm_voice_with_envelopes_top_tb.sv
// Testbench: drives notes and ticks into the FM voice and checks each sample against a predictor.
module fm_voice_with_envelopes_top_tb;
    import fmv_pkg::*;

    typedef struct packed {
        logic [11:0] code;
        logic        playing;
    } sample_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    fm_voice_with_envelopes_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // voice configuration copy
    longint      len_attack, len_sustain, len_decay;
    longint      len_mattack, len_msustain, len_mdecay;
    longint      peak_depth;
    bit          decay_is_linear;
    // voice state copy
    bit [31:0]   car_phase, mod_phase, elapsed, car_inc, mod_inc;
    int          amp, depth;
    int          steps [4];
    int          sine_tab [256];

    sample_t     sample_q [$];
    bit          quiet = 1'b0;
    int          fails = 0;
    int          n_items = 0;
    int          n_notes = 0;
    int          n_playing = 0;
    longint      cycles = 0;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic int clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fff_ffff;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return int'(v);
    endfunction

    function automatic int len_step(longint full, longint len);
        if (len == 0) return int'(STEP_SAT);
        return clamp32(full / len);
    endfunction

    task automatic build_sine();
        longint q, r, k, x, x2, term, acc, v;
        for (int i = 0; i < 256; i++) begin
            q = (i / 64) & 3;
            r = i % 64;
            k = q[0] ? 64 - r : r;
            x = (k * HALF_PI_Q30) / 64;
            x2 = (x * x) >>> 30;
            term = x;
            acc = x;
            for (int n = 1; n <= 7; n++) begin
                term = ((term * x2) >>> 30) / ((2 * n) * (2 * n + 1));
                acc = n[0] ? acc - term : acc + term;
            end
            v = floor_shift(SINE_AMP * acc, 30 - 15);
            sine_tab[i] = clamp32(q[1] ? -v : v);
        end
    endtask

    function automatic sample_t voice_sample(bit action, bit [31:0] ci, bit [31:0] mi);
        sample_t res;
        longint  n, mwave, cwave, fm, dk, twice, back;
        res.code = DAC_MID;
        res.playing = 1'b0;
        if (action) begin
            car_inc = ci;
            mod_inc = mi;
            steps[0] = len_step(64'sd1 << 15, len_attack);
            steps[1] = len_step(64'sd1 << 15, len_decay);
            steps[2] = len_step(peak_depth, len_mattack);
            steps[3] = len_step(peak_depth, len_mdecay);
            amp = steps[0];
            depth = steps[2];
            elapsed = 0;
            car_phase = 0;
        end
        if (amp > 0) begin
            n = longint'(elapsed);
            res.playing = 1'b1;
            mod_phase = mod_phase + mod_inc;
            mwave = sine_tab[mod_phase[31:24]];
            if (n < len_mattack + len_msustain + len_mdecay) begin
                if (n <= len_mattack)
                    depth = clamp32(longint'(depth) + steps[2]);
                else if (n > len_mattack + len_msustain)
                    depth = clamp32(longint'(depth) - steps[3]);
            end else begin
                depth = 0;
            end
            fm = floor_shift(mwave * depth, 15);
            car_phase = car_phase + car_inc + fm[31:0];
            cwave = sine_tab[car_phase[31:24]];
            if (n < len_attack + len_sustain + len_decay) begin
                if (n <= len_attack) begin
                    amp = clamp32(longint'(amp) + steps[0]);
                end else if (n > len_attack + len_sustain) begin
                    dk = steps[1];
                    if (decay_is_linear) begin
                        amp = clamp32(longint'(amp) - dk);
                    end else begin
                        twice = 2 * dk;
                        back = (len_decay != 0)
                            ? (twice * (n - len_attack - len_sustain)) / len_decay : 0;
                        amp = clamp32(longint'(amp) - twice + back);
                    end
                end
            end else begin
                amp = 0;
            end
            cwave = floor_shift(cwave * amp, 15);
            fm = floor_shift(cwave, 15) + 2048;
            res.code = fm[11:0];
            if (elapsed != 32'hffff_ffff) elapsed++;
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 4_000_000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet || ($urandom_range(0, 99) >= 37);
        end
    end

    always @(posedge aclk) begin
        sample_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (sample_q.size() == 0) begin
                $error("unexpected transfer m_tdata=%h", m_tdata);
                fails++;
            end else begin
                want = sample_q.pop_front();
                if (m_tdata[11:0] !== want.code) begin
                    $error("dac_code expected %0d actual %0d", want.code, m_tdata[11:0]);
                    fails++;
                end
                if (m_tdata[12] !== want.playing) begin
                    $error("playing expected %0d actual %0d", want.playing, m_tdata[12]);
                    fails++;
                end
            end
        end
    end

    task automatic send_item(bit action, bit [31:0] ci, bit [31:0] mi);
        while (!quiet && $urandom_range(0, 99) < 37) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= action;
        s_tdata <= {mi, ci};
        do @(posedge aclk); while (!s_tready);
        sample_q.push_back(voice_sample(action, ci, mi));
        n_items++;
        if (action) n_notes++;
        if (sample_q[$].playing) n_playing++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sample_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ATTACK:      len_attack = longint'(val[15:0]);
            REG_SUSTAIN:     len_sustain = longint'(val[15:0]);
            REG_DECAY:       len_decay = longint'(val[15:0]);
            REG_MOD_ATTACK:  len_mattack = longint'(val[15:0]);
            REG_MOD_SUSTAIN: len_msustain = longint'(val[15:0]);
            REG_MOD_DECAY:   len_mdecay = longint'(val[15:0]);
            REG_PEAK_DEPTH:  peak_depth = longint'(val[30:0]);
            REG_LINEAR:      decay_is_linear = val[0];
            default: ;
        endcase
    endtask

    task automatic set_voice(int a, int s, int d, int ma, int ms, int md,
                             logic [31:0] peak, bit lin);
        drain();
        reg_write(REG_ATTACK, a);
        reg_write(REG_SUSTAIN, s);
        reg_write(REG_DECAY, d);
        reg_write(REG_MOD_ATTACK, ma);
        reg_write(REG_MOD_SUSTAIN, ms);
        reg_write(REG_MOD_DECAY, md);
        reg_write(REG_PEAK_DEPTH, peak);
        reg_write(REG_LINEAR, {31'd0, lin});
    endtask

    task automatic test_silent_ticks();
        for (int i = 0; i < 3; i++) send_item(1'b0, $urandom, $urandom);
    endtask

    task automatic test_default_note();
        send_item(1'b1, 32'h0100_0000, 32'h0200_0000);
        for (int i = 0; i < 5; i++) send_item(1'b0, $urandom, $urandom);
    endtask

    task automatic test_zero_lengths();
        set_voice(0, 0, 0, 0, 0, 0, 32'h7fff_ffff, 1'b1);
        send_item(1'b1, 32'hffff_ffff, 32'hffff_ffff);
        send_item(1'b0, 32'h0, 32'h0);
        send_item(1'b0, 32'h0, 32'h0);
    endtask

    task automatic test_extreme_depth();
        set_voice(2, 1, 3, 1, 0, 2, 32'h7fff_ffff, 1'b0);
        send_item(1'b1, 32'h0, 32'hffff_ffff);
        for (int i = 0; i < 8; i++) send_item(1'b0, 32'hffff_ffff, 32'h0);
        set_voice(65535, 65535, 65535, 65535, 65535, 65535, 32'h0, 1'b1);
        send_item(1'b1, 32'hffff_ffff, 32'h0);
        send_item(1'b0, 32'h0, 32'hffff_ffff);
    endtask

    task automatic test_random_phase(int count);
        bit act;
        for (int i = 0; i < count; i++) begin
            act = ($urandom_range(0, 99) < 6);
            send_item(act, $urandom, $urandom);
        end
    endtask

    initial begin
        len_attack = 1000; len_sustain = 4000; len_decay = 8000;
        len_mattack = 1000; len_msustain = 4000; len_mdecay = 8000;
        peak_depth = 0; decay_is_linear = 1'b1;
        car_phase = 0; mod_phase = 0; elapsed = 0; car_inc = 0; mod_inc = 0;
        amp = 0; depth = 0;
        for (int i = 0; i < 4; i++) steps[i] = 0;
        build_sine();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_silent_ticks();
        test_default_note();
        test_zero_lengths();
        test_extreme_depth();

        for (int ph = 0; ph < 8; ph++) begin
            set_voice($urandom_range(0, 12), $urandom_range(0, 10), $urandom_range(0, 20),
                      $urandom_range(0, 12), $urandom_range(0, 10), $urandom_range(0, 20),
                      (ph == 3) ? 32'h7fff_ffff : ($urandom >> $urandom_range(0, 16)),
                      ph[0]);
            quiet = (ph == 5);
            test_random_phase(95);
        end
        quiet = 1'b0;
        drain();
        repeat (300) @(posedge aclk);

        $display("Covered %0d transfers, %0d note starts, %0d playing samples,", n_items,
                 n_notes, n_playing);
        $display("zero and full-scale lengths, both decay shapes and depth extremes.");
        if (fails == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
